// File: rtl/edoc_pkg.sv
// Package for the edit-distance-one candidate unit.
// Holds sizes, kind, edit and status codes and structs for all rtl files but edoc_ram.
`default_nettype none
package edoc_pkg;
	localparam int MaxWordDefault = 32;
	localparam int MaxAlphabetDefault = 64;
	localparam int CharW = 21;
	localparam int CandW = 13;
	localparam int AlphaCfgW = 7;
	localparam logic [AlphaCfgW-1:0] AlphaReset = 7'd26;

	typedef enum logic [1:0] {
		KIND_LOAD_WORD = 2'd0,
		KIND_LOAD_ALPHA = 2'd1,
		KIND_GENERATE = 2'd2,
		KIND_COUNT = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		EDIT_DEL = 2'd0,
		EDIT_TRANSP = 2'd1,
		EDIT_ALTER = 2'd2,
		EDIT_INSERT = 2'd3
	} edit_t;

	localparam logic [1:0] STATUS_OK = 2'd0;
	localparam logic [1:0] STATUS_RANGE = 2'd1;
	localparam logic [1:0] STATUS_POS = 2'd2;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;   // latch the accepted input
		logic div_start; // load remainder for the divide loop
		logic div_step;  // one subtract step of the divide loop
		logic classify;  // pick edit type and selected position
		logic emit_load; // start character emission
		logic emit_next; // advance emission one character
	} edoc_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic is_gen;     // captured input is a generate request
		logic in_range;   // candidate index below the total
		logic need_div;   // alteration or insertion
		logic div_done;   // remainder below the alphabet size
		logic emit_final; // current character is the last one
	} edoc_sts_t;
endpackage
`default_nettype wire

// File: rtl/edoc_ram.sv
// Generic single-port-write, one-read RAM with registered read data.
// No dependencies.
`default_nettype none
module edoc_ram #(
	parameter int Width = 21,
	parameter int Depth = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(Depth)-1:0] waddr,
	input  wire logic [Width-1:0]         wdata,
	input  wire logic [$clog2(Depth)-1:0] raddr,
	output logic      [Width-1:0]         rdata
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

// File: rtl/edoc_datapath.sv
// Datapath: word and alphabet stores, total count, index decomposition and
// character emission. Uses edoc_pkg and edoc_ram.
`default_nettype none
module edoc_datapath
	import edoc_pkg::*;
#(
	parameter int MaxWord = MaxWordDefault,
	parameter int MaxAlphabet = MaxAlphabetDefault
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic [AlphaCfgW-1:0] alpha_cfg,
	input  wire logic [1:0]           kind,
	input  wire logic [5:0]           position,
	input  wire logic [CharW-1:0]     char_in,
	input  wire logic                 word_last,
	input  wire logic [CandW-1:0]     candidate,
	input  wire edoc_cmd_t            cmd,
	output edoc_sts_t                 sts,
	output logic [CharW-1:0]          char_out,
	output logic                      char_valid,
	output logic [1:0]                edit_type,
	output logic [CandW-1:0]          total,
	output logic [1:0]                status,
	output logic                      empty_cand
);
	localparam int WAW = $clog2(MaxWord);
	localparam int AAW = $clog2(MaxAlphabet);
	localparam int LW = $clog2(MaxWord + 2);

	logic [LW-1:0]       wlen_q;
	logic [1:0]          kind_q;
	logic [CandW-1:0]    cand_q;
	logic [6:0]          act_a;
	logic [16:0]         full_t, t_al, t_in, t_dt;
	logic [LW-1:0]       n_tr;
	logic [CandW-1:0]    rem_q;
	logic [LW-1:0]       quo_q;
	logic [1:0]          type_q;
	logic [LW-1:0]       sel_q, cand_len, idx_q;
	logic                pos_bad;

	assign act_a = (alpha_cfg > 7'(MaxAlphabet)) ? 7'(MaxAlphabet) : alpha_cfg;
	assign n_tr = (wlen_q != '0) ? wlen_q - LW'(1) : '0;
	assign t_dt = 17'(wlen_q) + 17'(n_tr);
	assign t_al = 17'(act_a) * 17'(wlen_q);
	assign t_in = t_al + 17'(act_a);
	assign full_t = t_dt + t_al + t_in;
	assign total = (full_t > 17'd8191) ? 13'd8191 : full_t[CandW-1:0];

	assign pos_bad = (kind == KIND_LOAD_WORD) ? (7'(position) >= 7'(MaxWord))
		: (7'(position) >= 7'(MaxAlphabet));

	// Stores.
	logic            w_we, a_we;
	logic [WAW-1:0]  w_ra;
	logic [CharW-1:0] w_rd, a_rd;
	logic [AAW-1:0]  a_ra;
	logic            cap_load;
	assign cap_load = cmd.capture && !pos_bad;
	assign w_we = cap_load && (kind == KIND_LOAD_WORD);
	assign a_we = cap_load && (kind == KIND_LOAD_ALPHA);

	edoc_ram #(.Width(CharW), .Depth(MaxWord)) u_word (
		.clk, .we(w_we), .waddr(position[WAW-1:0]), .wdata(char_in),
		.raddr(w_ra), .rdata(w_rd));
	edoc_ram #(.Width(CharW), .Depth(MaxAlphabet)) u_alpha (
		.clk, .we(a_we), .waddr(position[AAW-1:0]), .wdata(char_in),
		.raddr(a_ra), .rdata(a_rd));

	// Classification of the candidate index.
	logic [16:0] c17, r_alter, r_ins;
	assign c17 = 17'(cand_q);
	assign r_alter = c17 - t_dt;
	assign r_ins = c17 - t_dt - t_al;
	assign sts.is_gen = (kind_q == KIND_GENERATE);
	assign sts.in_range = c17 < full_t;
	assign sts.need_div = c17 >= t_dt;
	assign sts.div_done = rem_q < CandW'(act_a);

	// Word index for the character being emitted (ram read address).
	logic [LW-1:0] ridx;
	logic [LW-1:0] cur;
	logic          letter_pos;
	assign cur = cmd.emit_load ? '0 : (cmd.emit_next ? idx_q + LW'(1) : idx_q);
	always_comb begin
		letter_pos = 1'b0;
		ridx = cur;
		case (type_q)
			EDIT_DEL: ridx = (cur < sel_q) ? cur : cur + LW'(1);
			EDIT_TRANSP: begin
				if (cur == sel_q) ridx = sel_q + LW'(1);
				else if (cur == sel_q + LW'(1)) ridx = sel_q;
			end
			EDIT_ALTER: letter_pos = (cur == sel_q);
			EDIT_INSERT: begin
				if (cur == sel_q) letter_pos = 1'b1;
				else if (cur > sel_q) ridx = cur - LW'(1);
			end
			default: ridx = cur;
		endcase
	end
	assign w_ra = ridx[WAW-1:0];
	assign a_ra = rem_q[AAW-1:0];

	logic lp_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wlen_q <= '0;
		end else if (w_we && word_last) begin
			wlen_q <= LW'(position) + LW'(1);
		end
	end

	always_ff @(posedge clk) begin
		lp_q <= letter_pos;
		if (cmd.capture) begin
			kind_q <= kind;
			cand_q <= candidate;
			// The range check uses the current total; a generate changes no state.
			if (kind == KIND_LOAD_WORD || kind == KIND_LOAD_ALPHA)
				status <= pos_bad ? STATUS_POS : STATUS_OK;
			else if (kind == KIND_GENERATE && 17'(candidate) >= full_t)
				status <= STATUS_RANGE;
			else
				status <= STATUS_OK;
		end
		if (cmd.div_start) begin
			quo_q <= '0;
			if (c17 < t_dt + t_al) begin
				type_q <= EDIT_ALTER;
				rem_q <= r_alter[CandW-1:0];
			end else begin
				type_q <= EDIT_INSERT;
				rem_q <= r_ins[CandW-1:0];
			end
		end else if (cmd.div_step) begin
			rem_q <= rem_q - CandW'(act_a);
			quo_q <= quo_q + LW'(1);
		end
		if (cmd.classify && !sts.need_div) begin
			if (c17 < 17'(wlen_q)) begin
				type_q <= EDIT_DEL;
				sel_q <= cand_q[LW-1:0];
			end else begin
				type_q <= EDIT_TRANSP;
				sel_q <= LW'(c17 - 17'(wlen_q));
			end
		end else if (cmd.classify) begin
			sel_q <= quo_q;
		end
		if (cmd.emit_load) idx_q <= '0;
		else if (cmd.emit_next) idx_q <= idx_q + LW'(1);
	end

	always_comb begin
		case (type_q)
			EDIT_DEL: cand_len = wlen_q - LW'(1);
			EDIT_INSERT: cand_len = wlen_q + LW'(1);
			default: cand_len = wlen_q;
		endcase
	end
	assign empty_cand = (cand_len == '0);
	assign sts.emit_final = (idx_q + LW'(1) >= cand_len);
	assign char_out = lp_q ? a_rd : w_rd;
	assign char_valid = !empty_cand;
	assign edit_type = type_q;
endmodule
`default_nettype wire

// File: rtl/edoc_ctrl.sv
// Controller state machine and output register for the candidate unit.
// Uses edoc_pkg; drives edoc_datapath through command and status structs.
`default_nettype none
module edoc_ctrl
	import edoc_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  in_valid,
	output logic       in_stall,
	input  wire logic  out_stall,
	output logic       out_valid,
	output logic       out_last,
	output logic       out_blank,
	output logic       ld_out,
	input  wire logic  empty_cand,
	input  wire edoc_sts_t sts,
	output edoc_cmd_t  cmd
);
	typedef enum logic [2:0] {
		S_IDLE, S_CLASS, S_DIV, S_FETCH, S_EMIT, S_SINGLE, S_WAIT
	} state_t;
	state_t state_q;
	logic   emitting;
	logic   emit_now;
	logic   gen_ok;

	assign in_stall = (state_q != S_IDLE);
	assign emitting = (state_q == S_EMIT);
	// Output register updates whenever it is empty or being taken.
	assign ld_out = !out_valid || !out_stall;
	assign emit_now = ld_out && (state_q == S_EMIT || state_q == S_SINGLE);
	assign gen_ok = sts.is_gen && sts.in_range;

	always_comb begin
		cmd = '0;
		cmd.capture = (state_q == S_IDLE) && in_valid;
		cmd.div_start = (state_q == S_CLASS) && gen_ok && sts.need_div;
		cmd.div_step = (state_q == S_DIV) && !sts.div_done;
		cmd.classify = (state_q == S_DIV) && sts.div_done
			|| (state_q == S_CLASS) && gen_ok && !sts.need_div;
		cmd.emit_load = cmd.classify;
		cmd.emit_next = emitting && ld_out && !sts.emit_final;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid <= 1'b0;
			out_last <= 1'b0;
			out_blank <= 1'b0;
		end else begin
			if (emit_now) out_valid <= 1'b1;
			else if (!out_stall) out_valid <= 1'b0;
			case (state_q)
				S_IDLE: if (in_valid) state_q <= S_CLASS;
				S_CLASS: begin
					if (!sts.is_gen || !sts.in_range) state_q <= S_SINGLE;
					else if (sts.need_div) state_q <= S_DIV;
					else state_q <= S_FETCH;
				end
				S_DIV: if (sts.div_done) state_q <= S_FETCH;
				S_FETCH: state_q <= (empty_cand) ? S_SINGLE : S_EMIT;
				S_EMIT: begin
					if (ld_out) begin
						out_last <= sts.emit_final;
						out_blank <= 1'b0;
						if (sts.emit_final) state_q <= S_WAIT;
						else state_q <= S_FETCH;
					end
				end
				S_SINGLE: begin
					if (ld_out) begin
						out_last <= 1'b1;
						out_blank <= 1'b1;
						state_q <= S_WAIT;
					end
				end
				S_WAIT: if (!out_valid || !out_stall) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !in_stall) else $error("idle must accept");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step |-> !cmd.classify) else $error("divide overlap");
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid) else $error("result dropped");
endmodule
`default_nettype wire

// File: rtl/edit_distance_one_candidates_unit.sv
// Top level of the edit-distance-one candidate unit.
// After accept, loads, counts and rejected requests go via S_CLASS and S_SINGLE to the
// output register; a generate goes via S_CLASS, S_DIV while the remainder is at least
// the alphabet size (alterations and insertions), then S_FETCH and S_EMIT per character,
// waiting in S_EMIT while the output stalls. One transaction is handled at a time.
// Reset: word length clears and alphabet_size returns to 26; stores are undefined.
`default_nettype none
module edit_distance_one_candidates_unit
	import edoc_pkg::*;
#(
	parameter int MaxWord = MaxWordDefault,
	parameter int MaxAlphabet = MaxAlphabetDefault
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic [1:0]           kind,
	input  wire logic [5:0]           position,
	input  wire logic [CharW-1:0]     char_in,
	input  wire logic                 word_last,
	input  wire logic [CandW-1:0]     candidate,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic [CharW-1:0]          char_out,
	output logic                      char_valid,
	output logic [1:0]                edit_type,
	output logic                      last,
	output logic [CandW-1:0]          total,
	output logic [1:0]                status,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [AlphaCfgW-1:0] cfg_data
);
	logic [AlphaCfgW-1:0] alpha_q;
	edoc_cmd_t cmd;
	edoc_sts_t sts;
	logic [CharW-1:0] d_char;
	logic d_cv, empty_cand, ld_out, blank, o_last;
	logic [1:0] d_type, d_status;
	logic [CandW-1:0] d_total;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) alpha_q <= AlphaReset;
		else if (cfg_valid) alpha_q <= cfg_data;
	end

	edoc_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_stall, .out_stall, .out_valid,
		.out_last(o_last), .out_blank(blank), .ld_out, .empty_cand, .sts, .cmd);

	edoc_datapath #(.MaxWord(MaxWord), .MaxAlphabet(MaxAlphabet)) u_dp (
		.clk, .arst_n, .alpha_cfg(alpha_q), .kind, .position, .char_in,
		.word_last, .candidate, .cmd, .sts, .char_out(d_char), .char_valid(d_cv),
		.edit_type(d_type), .total(d_total), .status(d_status), .empty_cand);

	logic [CharW-1:0] char_q;
	logic cv_q;
	logic [1:0] type_q, st_q;
	logic [CandW-1:0] tot_q;
	always_ff @(posedge clk) begin
		if (ld_out) begin
			char_q <= d_char;
			cv_q <= d_cv;
			type_q <= d_type;
			st_q <= d_status;
			tot_q <= d_total;
		end
	end
	assign char_out = blank ? '0 : char_q;
	assign char_valid = blank ? 1'b0 : cv_q;
	assign edit_type = blank ? EDIT_DEL : type_q;
	assign last = o_last;
	assign total = tot_q;
	assign status = st_q;
endmodule
`default_nettype wire

// File: sim/tb.sv
// Testbench for the edit-distance-one candidate unit: loads words and alphabets,
// queries counts and generates candidates, and checks every result against a predictor.
// Depends on edoc_pkg and edit_distance_one_candidates_unit.
`default_nettype none

module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import edoc_pkg::*;

	localparam int MaxWord = MaxWordDefault;
	localparam int MaxAlpha = MaxAlphabetDefault;

	typedef struct packed {
		logic [CharW-1:0] char_out;
		logic             char_valid;
		logic [1:0]       edit_type;
		logic             last;
		logic [CandW-1:0] total;
		logic [1:0]       status;
	} cand_char_t;

	typedef struct packed {
		logic [1:0]       kind;
		logic [5:0]       position;
		logic [CharW-1:0] char_in;
		logic             word_last;
		logic [CandW-1:0] candidate;
	} request_t;

	// Predicts the unit's results and holds those not yet seen.
	class candidate_scoreboard;
		logic [CharW-1:0] word_chars [MaxWord];
		logic [CharW-1:0] alpha_chars [MaxAlpha];
		int unsigned word_len;
		int unsigned alpha_cfg;
		cand_char_t pending [$];
		int errors;

		function new();
			word_len = 0;
			alpha_cfg = AlphaReset;
			errors = 0;
			foreach (word_chars[i]) word_chars[i] = '0;
			foreach (alpha_chars[i]) alpha_chars[i] = '0;
		endfunction

		function int unsigned active_alpha();
			return (alpha_cfg > MaxAlpha) ? MaxAlpha : alpha_cfg;
		endfunction

		function int unsigned candidate_count();
			int unsigned a;
			a = active_alpha();
			return word_len + ((word_len > 0) ? word_len - 1 : 0) + a * word_len
				+ a * (word_len + 1);
		endfunction

		function void push(logic [CharW-1:0] c, logic v, logic [1:0] t, logic l,
				logic [1:0] st);
			cand_char_t r;
			int unsigned n;
			n = candidate_count();
			r.char_out = c;
			r.char_valid = v;
			r.edit_type = t;
			r.last = l;
			r.total = (n > 8191) ? 13'd8191 : n[CandW-1:0];
			r.status = st;
			pending.push_back(r);
		endfunction

		function logic [CharW-1:0] wc(int unsigned i);
			return (i < MaxWord) ? word_chars[i] : '0;
		endfunction

		function void note_request(request_t q);
			int unsigned l, a, n, c, sel, len, r;
			logic [CharW-1:0] letter, ch;
			edit_t et;
			l = word_len;
			a = active_alpha();
			c = q.candidate;
			sel = 0;
			letter = '0;
			case (kind_t'(q.kind))
				KIND_LOAD_WORD: begin
					if (q.position >= MaxWord) begin
						push('0, 0, EDIT_DEL, 1, STATUS_POS);
					end else begin
						word_chars[q.position] = q.char_in;
						if (q.word_last) word_len = q.position + 1;
						push('0, 0, EDIT_DEL, 1, STATUS_OK);
					end
				end
				KIND_LOAD_ALPHA: begin
					if (q.position >= MaxAlpha) begin
						push('0, 0, EDIT_DEL, 1, STATUS_POS);
					end else begin
						alpha_chars[q.position] = q.char_in;
						push('0, 0, EDIT_DEL, 1, STATUS_OK);
					end
				end
				KIND_COUNT: push('0, 0, EDIT_DEL, 1, STATUS_OK);
				default: begin
					if (c >= candidate_count()) begin
						push('0, 0, EDIT_DEL, 1, STATUS_RANGE);
						return;
					end
					n = (l > 0) ? l - 1 : 0;
					if (c < l) begin
						et = EDIT_DEL; sel = c; len = l - 1;
					end else if (c < l + n) begin
						et = EDIT_TRANSP; sel = c - l; len = l;
					end else if (c < l + n + a * l) begin
						r = c - l - n;
						et = EDIT_ALTER; sel = r / a; letter = alpha_chars[r % a]; len = l;
					end else begin
						r = c - l - n - a * l;
						et = EDIT_INSERT; sel = r / a; letter = alpha_chars[r % a];
						len = l + 1;
					end
					if (len == 0) begin
						push('0, 0, EDIT_DEL, 1, STATUS_OK);
						return;
					end
					for (int unsigned i = 0; i < len; i++) begin
						case (et)
							EDIT_DEL: ch = wc(i < sel ? i : i + 1);
							EDIT_TRANSP: ch = (i == sel) ? wc(sel + 1) :
								(i == sel + 1) ? wc(sel) : wc(i);
							EDIT_ALTER: ch = (i == sel) ? letter : wc(i);
							default: ch = (i < sel) ? wc(i) : (i == sel) ? letter : wc(i - 1);
						endcase
						push(ch, 1, et, i + 1 == len, STATUS_OK);
					end
				end
			endcase
		endfunction

		function void check_result(cand_char_t got);
			cand_char_t exp;
			if (pending.size() == 0) begin
				$error("unexpected result %p", got);
				errors++;
				return;
			end
			exp = pending.pop_front();
			if (got.char_out !== exp.char_out) begin
				$error("char_out: expected %0h, actual %0h", exp.char_out, got.char_out);
				errors++;
			end
			if (got.char_valid !== exp.char_valid) begin
				$error("char_valid: expected %0d, actual %0d", exp.char_valid, got.char_valid);
				errors++;
			end
			if (got.edit_type !== exp.edit_type) begin
				$error("edit_type: expected %0d, actual %0d", exp.edit_type, got.edit_type);
				errors++;
			end
			if (got.last !== exp.last) begin
				$error("last: expected %0d, actual %0d", exp.last, got.last);
				errors++;
			end
			if (got.total !== exp.total) begin
				$error("total: expected %0d, actual %0d", exp.total, got.total);
				errors++;
			end
			if (got.status !== exp.status) begin
				$error("status: expected %0d, actual %0d", exp.status, got.status);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_stall;
	logic [1:0] kind = '0;
	logic [5:0] position = '0;
	logic [CharW-1:0] char_in = '0;
	logic word_last = 0;
	logic [CandW-1:0] candidate = '0;
	logic out_valid;
	logic out_stall = 0;
	logic [CharW-1:0] char_out;
	logic char_valid;
	logic [1:0] edit_type;
	logic last;
	logic [CandW-1:0] total;
	logic [1:0] status;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [AlphaCfgW-1:0] cfg_data = '0;

	candidate_scoreboard sb = new();
	// Word and alphabet entries written so far; reads of others are never caused.
	bit word_known [MaxWord];
	int unsigned alpha_known_n;
	int burst_left;

	edit_distance_one_candidates_unit u_top (.*);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	// Receiver stall pattern: alternating calm and busy stretches.
	int unsigned stall_phase;
	always @(posedge clk) begin
		cand_char_t r;
		if (arst_n && out_valid && !out_stall) begin
			r.char_out = char_out;
			r.char_valid = char_valid;
			r.edit_type = edit_type;
			r.last = last;
			r.total = total;
			r.status = status;
			sb.check_result(r);
		end
		stall_phase <= stall_phase + 1;
		if (stall_phase[8]) out_stall <= 0;
		else out_stall <= ($urandom_range(0, 3) == 0);
	end

	// Valid stays high after acceptance; the next send or drain in the same step replaces it.
	task automatic send(request_t q);
		if (burst_left == 0) begin
			in_valid <= 0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = $urandom_range(1, 12);
		end
		in_valid <= 1;
		kind <= q.kind;
		position <= q.position;
		char_in <= q.char_in;
		word_last <= q.word_last;
		candidate <= q.candidate;
		do @(posedge clk); while (in_stall);
		sb.note_request(q);
		if (q.kind == KIND_LOAD_WORD && q.position < MaxWord) word_known[q.position] = 1;
		if (q.kind == KIND_LOAD_ALPHA && q.position < MaxAlpha && q.position >= alpha_known_n)
			alpha_known_n = q.position + 1;
		burst_left--;
	endtask

	task automatic drain();
		in_valid <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (120) @(posedge clk);
	endtask

	task automatic write_alpha_size(int unsigned v);
		drain();
		cfg_valid <= 1;
		cfg_data <= v[AlphaCfgW-1:0];
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
		sb.alpha_cfg = v;
		@(posedge clk);
	endtask

	function automatic request_t mk(logic [1:0] k, int unsigned pos, int unsigned ch,
			bit wl, int unsigned cand);
		request_t q;
		q.kind = k;
		q.position = pos[5:0];
		q.char_in = ch[CharW-1:0];
		q.word_last = wl;
		q.candidate = cand[CandW-1:0];
		return q;
	endfunction

	// Loads every alphabet entry (whole store so all reads stay defined).
	task automatic load_alphabet();
		for (int i = 0; i < MaxAlpha; i++)
			send(mk(KIND_LOAD_ALPHA, i, $urandom_range(0, 1114111), 0, 0));
	endtask

	task automatic load_word(int unsigned len);
		for (int i = 0; i < len; i++)
			send(mk(KIND_LOAD_WORD, i, $urandom_range(0, 1114111), i + 1 == len, 0));
	endtask

	// Generates a candidate; about one in ten, and every one when the count is zero, is out of range.
	task automatic gen_random();
		int unsigned n;
		n = sb.candidate_count();
		if ($urandom_range(0, 9) == 0 || n == 0)
			send(mk(KIND_GENERATE, 0, $urandom, 0, $urandom_range(n, 8191)));
		else
			send(mk(KIND_GENERATE, $urandom, $urandom, $urandom, $urandom_range(0, n - 1)));
	endtask

	initial begin
		int unsigned sizes [5] = '{1, 64, 127, 2, 26};
		int unsigned n;
		burst_left = 0;
		alpha_known_n = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed part: empty word, extremes, every kind and special case.
		send(mk(KIND_COUNT, 0, 0, 0, 0));
		send(mk(KIND_GENERATE, 0, 0, 0, 8191));
		send(mk(KIND_LOAD_WORD, 63, 1114111, 1, 0));
		send(mk(KIND_LOAD_WORD, 32, 5, 0, 0));
		send(mk(KIND_LOAD_ALPHA, 63, 1114111, 0, 0));
		load_alphabet();
		send(mk(KIND_GENERATE, 0, 0, 0, 0));
		send(mk(KIND_GENERATE, 0, 0, 0, 25));
		send(mk(KIND_LOAD_WORD, 0, 1114111, 1, 0));
		send(mk(KIND_GENERATE, 0, 0, 0, 0));
		send(mk(KIND_LOAD_WORD, 1, 0, 0, 0));
		send(mk(KIND_COUNT, 63, 1114111, 1, 8191));
		load_word(MaxWord);
		send(mk(KIND_GENERATE, 0, 0, 0, 0));
		send(mk(KIND_GENERATE, 0, 0, 0, 31));
		send(mk(KIND_GENERATE, 0, 0, 0, 32));
		send(mk(KIND_GENERATE, 0, 0, 0, sb.candidate_count() - 1));
		send(mk(KIND_GENERATE, 0, 0, 0, sb.candidate_count()));

		// Pause until everything is back, then sweep the alphabet size.
		foreach (sizes[s]) begin
			write_alpha_size(sizes[s]);
			for (int i = 0; i < 25; i++) begin
				n = $urandom_range(0, 19);
				if (n < 2) load_word($urandom_range(0, 3) == 0 ? MaxWord : $urandom_range(1, 6));
				else if (n < 4) send(mk(KIND_LOAD_WORD, $urandom, $urandom, 0, $urandom));
				else if (n < 5) send(mk(KIND_LOAD_ALPHA, $urandom, $urandom, $urandom, $urandom));
				else if (n < 6) send(mk(KIND_COUNT, $urandom, $urandom, $urandom, $urandom));
				else gen_random();
			end
		end
		write_alpha_size(0);
		for (int i = 0; i < 8; i++) gen_random();
		send(mk(KIND_COUNT, 0, 0, 0, 0));

		drain();
		if (sb.errors == 0) $display("status: pass");
		else $display("status: fail");
		$finish;
	end

	initial begin
		#20ms;
		$display("status: fail");
		$finish;
	end
endmodule

`default_nettype wire

// File: files.f
rtl/edoc_pkg.sv
rtl/edoc_ram.sv
rtl/edoc_datapath.sv
rtl/edoc_ctrl.sv
rtl/edit_distance_one_candidates_unit.sv
sim/tb.sv
